[rtl/spdf_pkg.sv]
// Package for the serial packet deframer: phase and register codes, result struct.
// No dependencies; the top level, the state machine and the testbench import it.
package spdf_pkg;

  localparam logic [7:0] SYNC_BYTE = 8'hFF;
  localparam logic [8:0] SUM_MOD   = 9'd255;

  typedef enum logic [2:0] {
    PH_SYNC1,
    PH_SYNC2,
    PH_SENDER,
    PH_RECV,
    PH_LENHI,
    PH_LENLO,
    PH_PAYLOAD,
    PH_CHECK
  } phase_e;

  typedef enum logic {
    CFG_OWN_ID,
    CFG_EXP_SENDER
  } cfg_idx_e;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic        payload_last;
    logic        frame_good;
    logic        frame_bad;
    logic [15:0] frame_length;
  } res_t;

endpackage

[rtl/spdf_in_if.sv]
// Byte input channel of the deframer: valid, ready and the received byte.
// Depends on nothing.
interface spdf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

[rtl/spdf_out_if.sv]
// Result channel of the deframer: valid, ready and the per-byte result fields.
// Depends on nothing.
interface spdf_out_if;
  logic        valid;
  logic        ready;
  logic        payload_valid;
  logic [7:0]  payload_byte;
  logic [15:0] payload_index;
  logic        payload_last;
  logic        frame_good;
  logic        frame_bad;
  logic [15:0] frame_length;

  modport source (output valid, output payload_valid, output payload_byte,
                  output payload_index, output payload_last, output frame_good,
                  output frame_bad, output frame_length, input ready);
  modport sink (input valid, input payload_valid, input payload_byte,
                input payload_index, input payload_last, input frame_good,
                input frame_bad, input frame_length, output ready);
endinterface

[rtl/serial_packet_deframer_top.sv]
// Serial packet deframer top level: configuration registers, input register,
// result register. Depends on spdf_pkg, spdf_in_if, spdf_out_if and spdf_fsm.
// A byte transfer passes through the input register, then the result register.
// Throughput: one byte per cycle while the result channel is not stalled, set by
// the frame state update that runs once per byte. Reset returns to the sync hunt
// with an empty pipeline and sets both ID registers to 1.
module serial_packet_deframer_top import spdf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  spdf_in_if.sink    in_i,
  spdf_out_if.source out_o
);

  logic [7:0] own_id_q;
  logic [7:0] exp_sender_q;
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       out_valid_q;
  res_t       res_q;
  res_t       res_d;
  logic       out_adv;
  logic       step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_id_q     <= 8'd1;
      exp_sender_q <= 8'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_OWN_ID:     own_id_q     <= cfg_data_i;
        CFG_EXP_SENDER: exp_sender_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign out_adv     = !out_valid_q || out_o.ready;
  assign step        = s1_valid_q && out_adv;
  assign in_i.ready  = !s1_valid_q || out_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (out_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_byte_q <= in_i.rx_byte;
    end
    if (step) begin
      res_q <= res_d;
    end
  end

  spdf_fsm u_fsm (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .rx_byte_i    (s1_byte_q),
    .own_id_i     (own_id_q),
    .exp_sender_i (exp_sender_q),
    .res_o        (res_d)
  );

  assign out_o.valid         = out_valid_q;
  assign out_o.payload_valid = res_q.payload_valid;
  assign out_o.payload_byte  = res_q.payload_byte;
  assign out_o.payload_index = res_q.payload_index;
  assign out_o.payload_last  = res_q.payload_last;
  assign out_o.frame_good    = res_q.frame_good;
  assign out_o.frame_bad     = res_q.frame_bad;
  assign out_o.frame_length  = res_q.frame_length;

  a_good_bad_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(res_q.frame_good && res_q.frame_bad))
    else $error("frame flagged good and bad at once");

  a_last_needs_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.payload_last) |-> res_q.payload_valid)
    else $error("payload_last without a payload byte");

  a_check_not_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (res_q.frame_good || res_q.frame_bad)) |-> !res_q.payload_valid)
    else $error("checksum result on a payload byte");

  a_stall_holds_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_adv) |=> s1_valid_q && $stable(s1_byte_q))
    else $error("input register lost a byte while stalled");

endmodule

[rtl/spdf_fsm.sv]
// Frame state machine: phase, mod-255 running sum, length and payload counter.
// Computes the result for one byte combinationally. Depends on spdf_pkg.
module spdf_fsm import spdf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] rx_byte_i,
  input  logic [7:0] own_id_i,
  input  logic [7:0] exp_sender_i,
  output res_t       res_o
);

  phase_e      phase_q, phase_d;
  logic [7:0]  sum_q, sum_d;
  logic [15:0] length_q, length_d;
  logic [15:0] count_q, count_d;
  logic [8:0]  sum_add;
  logic [7:0]  sum_next;
  logic        is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_SYNC1;
      sum_q    <= '0;
      length_q <= '0;
      count_q  <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      sum_q    <= sum_d;
      length_q <= length_d;
      count_q  <= count_d;
    end
  end

  assign sum_add  = {1'b0, sum_q} + {1'b0, rx_byte_i};
  assign sum_next = (sum_add >= SUM_MOD) ? 8'(sum_add - SUM_MOD) : sum_add[7:0];
  assign is_last  = ({1'b0, count_q} + 17'd1) >= {1'b0, length_q};

  always_comb begin
    phase_d  = phase_q;
    sum_d    = sum_q;
    length_d = length_q;
    count_d  = count_q;
    res_o    = '0;
    case (phase_q)
      PH_SYNC1: begin
        if (rx_byte_i == SYNC_BYTE) begin
          // The sync byte is zero modulo 255, so the sum restarts at zero.
          sum_d    = '0;
          length_d = '0;
          count_d  = '0;
          phase_d  = PH_SYNC2;
        end
      end
      PH_SYNC2: begin
        phase_d = (rx_byte_i == SYNC_BYTE) ? PH_SENDER : PH_SYNC1;
      end
      PH_SENDER: begin
        if (rx_byte_i == exp_sender_i) begin
          sum_d   = sum_next;
          phase_d = PH_RECV;
        end else begin
          phase_d = PH_SYNC1;
        end
      end
      PH_RECV: begin
        if (rx_byte_i == own_id_i) begin
          sum_d   = sum_next;
          phase_d = PH_LENHI;
        end else begin
          phase_d = PH_SYNC1;
        end
      end
      PH_LENHI: begin
        sum_d    = sum_next;
        length_d = length_q | {rx_byte_i, 8'h00};
        phase_d  = PH_LENLO;
      end
      PH_LENLO: begin
        sum_d    = sum_next;
        length_d = length_q | {8'h00, rx_byte_i};
        phase_d  = PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        sum_d               = sum_next;
        count_d             = count_q + 16'd1;
        res_o.payload_valid = 1'b1;
        res_o.payload_byte  = rx_byte_i;
        res_o.payload_index = count_q;
        if (is_last) begin
          res_o.payload_last = 1'b1;
          phase_d            = PH_CHECK;
        end
      end
      PH_CHECK: begin
        res_o.frame_good = (rx_byte_i == sum_q);
        res_o.frame_bad  = (rx_byte_i != sum_q);
        phase_d          = PH_SYNC1;
      end
      default: begin
        phase_d = PH_SYNC1;
      end
    endcase
    res_o.frame_length = length_d;
  end

endmodule

[sim/serial_packet_deframer_top_tb.sv]
// Self-checking testbench for serial_packet_deframer_top: a scoreboard class predicts
// one result per received byte and checks every result transfer in order.
// Depends on spdf_pkg, spdf_in_if, spdf_out_if and the deframer RTL.
`timescale 1ns / 1ps

import spdf_pkg::*;

class deframer_scoreboard;
  logic [7:0]  own_id;
  logic [7:0]  exp_sender;
  phase_e      phase;
  logic [7:0]  frame_sum;
  logic [15:0] frame_len;
  logic [15:0] payload_cnt;
  res_t        byte_results_q[$];
  int          errors;
  int          n_results;
  int          n_good;
  int          n_bad;
  int          n_payload;
  int          longest_frame;

  function new();
    own_id        = 8'd1;
    exp_sender    = 8'd1;
    phase         = PH_SYNC1;
    frame_sum     = '0;
    frame_len     = '0;
    payload_cnt   = '0;
    errors        = 0;
    n_results     = 0;
    n_good        = 0;
    n_bad         = 0;
    n_payload     = 0;
    longest_frame = 0;
  endfunction

  function void set_reg(cfg_idx_e idx, logic [7:0] value);
    if (idx == CFG_OWN_ID) begin
      own_id = value;
    end else begin
      exp_sender = value;
    end
  endfunction

  function void add_to_sum(logic [7:0] b);
    frame_sum = 8'((int'(frame_sum) + int'(b)) % int'(SUM_MOD));
  endfunction

  function void deframe_byte(logic [7:0] b);
    res_t r;
    r = '0;
    case (phase)
      PH_SYNC1: begin
        if (b == SYNC_BYTE) begin
          frame_sum   = '0;
          frame_len   = '0;
          payload_cnt = '0;
          add_to_sum(b);
          phase = PH_SYNC2;
        end
      end
      PH_SYNC2: begin
        if (b == SYNC_BYTE) begin
          add_to_sum(b);
          phase = PH_SENDER;
        end else begin
          phase = PH_SYNC1;
        end
      end
      PH_SENDER: begin
        if (b == exp_sender) begin
          add_to_sum(b);
          phase = PH_RECV;
        end else begin
          phase = PH_SYNC1;
        end
      end
      PH_RECV: begin
        if (b == own_id) begin
          add_to_sum(b);
          phase = PH_LENHI;
        end else begin
          phase = PH_SYNC1;
        end
      end
      PH_LENHI: begin
        add_to_sum(b);
        frame_len = frame_len | {b, 8'h00};
        phase = PH_LENLO;
      end
      PH_LENLO: begin
        add_to_sum(b);
        frame_len = frame_len | {8'h00, b};
        phase = PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        add_to_sum(b);
        r.payload_valid = 1'b1;
        r.payload_byte  = b;
        r.payload_index = payload_cnt;
        payload_cnt = payload_cnt + 16'd1;
        // A zero length still ends the frame after one payload byte.
        if (int'(r.payload_index) + 1 >= int'(frame_len)) begin
          r.payload_last = 1'b1;
          phase = PH_CHECK;
        end
      end
      PH_CHECK: begin
        if (b == frame_sum) begin
          r.frame_good = 1'b1;
        end else begin
          r.frame_bad = 1'b1;
        end
        phase = PH_SYNC1;
      end
      default: begin
        phase = PH_SYNC1;
      end
    endcase
    r.frame_length = frame_len;
    byte_results_q.push_back(r);
  endfunction

  function void compare(string field, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      errors++;
    end
  endfunction

  function void check_result(res_t got);
    res_t want;
    if (byte_results_q.size() == 0) begin
      $error("result transfer with no received byte waiting for it");
      errors++;
      return;
    end
    want = byte_results_q.pop_front();
    n_results++;
    compare("payload_valid", 16'(want.payload_valid), 16'(got.payload_valid));
    compare("payload_byte", 16'(want.payload_byte), 16'(got.payload_byte));
    compare("payload_index", want.payload_index, got.payload_index);
    compare("payload_last", 16'(want.payload_last), 16'(got.payload_last));
    compare("frame_good", 16'(want.frame_good), 16'(got.frame_good));
    compare("frame_bad", 16'(want.frame_bad), 16'(got.frame_bad));
    compare("frame_length", want.frame_length, got.frame_length);
    if (want.frame_good) n_good++;
    if (want.frame_bad) n_bad++;
    if (want.payload_valid) n_payload++;
    if (want.payload_last && int'(want.payload_index) + 1 > longest_frame) begin
      longest_frame = int'(want.payload_index) + 1;
    end
  endfunction

  function int pending();
    return byte_results_q.size();
  endfunction
endclass

module serial_packet_deframer_top_tb;

  localparam int PIPE_LATENCY = 2;
  localparam int LONG_HOLD    = 300;
  localparam int QUIET_LIMIT  = 5000;
  localparam int FLUSH_CYCLES = 10;

  typedef enum {CHK_GOOD, CHK_BAD, CHK_FF} chk_kind_e;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  cfg_idx_e   cfg_idx_i;
  logic [7:0] cfg_data_i;

  spdf_in_if  in_if ();
  spdf_out_if out_if ();

  serial_packet_deframer_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  deframer_scoreboard sb = new();

  logic [7:0] stim_q[$];
  logic [7:0] cur_own    = 8'd1;
  logic [7:0] cur_sender = 8'd1;
  int         items_sent = 0;
  int         burst_left = 0;
  bit         hold_req   = 1'b0;
  int         quiet      = 0;
  res_t       seen;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result monitor.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      seen.payload_valid = out_if.payload_valid;
      seen.payload_byte  = out_if.payload_byte;
      seen.payload_index = out_if.payload_index;
      seen.payload_last  = out_if.payload_last;
      seen.frame_good    = out_if.frame_good;
      seen.frame_bad     = out_if.frame_bad;
      seen.frame_length  = out_if.frame_length;
      sb.check_result(seen);
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver: modes of steady, random and periodic stalls, plus one long hold on request.
  initial begin
    int mode;
    int mode_left;
    int hold_left;
    int period;
    int tick;
    bit rdy;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    period    = 4;
    tick      = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LONG_HOLD - 1;
        rdy = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(32, 256);
          period    = $urandom_range(2, 7);
        end
        mode_left--;
        tick++;
        case (mode)
          0: rdy = 1'b1;
          1: rdy = $urandom_range(0, 99) >= 30;
          2: rdy = (tick % period) != 0;
          default: rdy = $urandom_range(0, 99) >= 75;
        endcase
      end
      out_if.ready <= rdy;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 9) < 2) begin
        gap = 0;
      end else if ($urandom_range(0, 9) < 8) begin
        gap = $urandom_range(1, 4);
      end else begin
        gap = $urandom_range(5, 24);
      end
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_if.valid   <= 1'b1;
    in_if.rx_byte <= b;
    do @(posedge clk_i); while (!in_if.ready);
    sb.deframe_byte(b);
    items_sent++;
  endtask

  task automatic send_stim();
    while (stim_q.size() != 0) begin
      send_byte(stim_q.pop_front());
    end
  endtask

  task automatic in_idle();
    in_if.valid <= 1'b0;
    burst_left = 0;
  endtask

  task automatic add_frame(input logic [7:0] snd, input logic [7:0] rcv,
                           input logic [15:0] len, input chk_kind_e kind);
    int sum;
    int n;
    logic [7:0] b;
    logic [7:0] chk;
    sum = 0;
    stim_q.push_back(SYNC_BYTE);
    stim_q.push_back(SYNC_BYTE);
    stim_q.push_back(snd);
    stim_q.push_back(rcv);
    stim_q.push_back(len[15:8]);
    stim_q.push_back(len[7:0]);
    sum = (2 * int'(SYNC_BYTE) + int'(snd) + int'(rcv) + int'(len[15:8]) + int'(len[7:0]))
          % int'(SUM_MOD);
    n = (len == 16'd0) ? 1 : int'(len);
    repeat (n) begin
      b = 8'($urandom_range(0, 255));
      stim_q.push_back(b);
      sum = (sum + int'(b)) % int'(SUM_MOD);
    end
    case (kind)
      CHK_GOOD: chk = 8'(sum);
      CHK_BAD:  chk = 8'((sum + $urandom_range(1, 254)) % int'(SUM_MOD));
      default:  chk = SYNC_BYTE;
    endcase
    stim_q.push_back(chk);
  endtask

  // Header fragments that fail at the second sync byte or at one of the IDs.
  task automatic add_broken();
    int r;
    r = $urandom_range(0, 2);
    stim_q.push_back(SYNC_BYTE);
    if (r == 0) begin
      stim_q.push_back(8'($urandom_range(0, 254)));
    end else begin
      stim_q.push_back(SYNC_BYTE);
      if (r == 1) begin
        stim_q.push_back(8'(cur_sender + 8'($urandom_range(1, 255))));
      end else begin
        stim_q.push_back(cur_sender);
        stim_q.push_back(8'(cur_own + 8'($urandom_range(1, 255))));
      end
    end
  endtask

  task automatic random_traffic(input int n_items);
    int stop_at;
    int pick;
    int r;
    logic [15:0] len;
    chk_kind_e kind;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        r = $urandom_range(0, 99);
        if (r < 80) begin
          len = 16'($urandom_range(0, 12));
        end else if (r < 96) begin
          len = 16'($urandom_range(13, 64));
        end else begin
          len = 16'($urandom_range(65, 300));
        end
        r = $urandom_range(0, 99);
        kind = (r < 75) ? CHK_GOOD : ((r < 93) ? CHK_BAD : CHK_FF);
        add_frame(cur_sender, cur_own, len, kind);
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 6)) stim_q.push_back(8'($urandom_range(0, 254)));
      end else begin
        add_broken();
      end
      send_stim();
    end
  endtask

  // Both registers are written back to back once all results are in.
  task automatic set_ids(input logic [7:0] own, input logic [7:0] snd);
    in_idle();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY + 2) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_OWN_ID;
    cfg_data_i <= own;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_EXP_SENDER;
    cfg_data_i <= snd;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(CFG_OWN_ID, own);
    sb.set_reg(CFG_EXP_SENDER, snd);
    cur_own    = own;
    cur_sender = snd;
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_OWN_ID;
    cfg_data_i    = 8'h00;
    in_if.valid   = 1'b0;
    in_if.rx_byte = 8'h00;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed bytes with the reset IDs: a second byte that is not a sync byte,
    // a wrong sender, a wrong receiver, a zero-length frame and a checksum of 0xFF.
    stim_q.push_back(SYNC_BYTE);
    stim_q.push_back(8'h00);
    stim_q.push_back(SYNC_BYTE);
    stim_q.push_back(SYNC_BYTE);
    stim_q.push_back(8'h02);
    stim_q.push_back(SYNC_BYTE);
    stim_q.push_back(SYNC_BYTE);
    stim_q.push_back(8'h01);
    stim_q.push_back(8'h00);
    add_frame(8'h01, 8'h01, 16'd0, CHK_GOOD);
    add_frame(8'h01, 8'h01, 16'd1, CHK_FF);
    send_stim();

    set_ids(8'h00, 8'hFF);
    hold_req = 1'b1;
    random_traffic(300);

    set_ids(8'hFF, 8'h00);
    random_traffic(300);

    set_ids(8'($urandom), 8'($urandom));
    random_traffic(300);
    add_frame(cur_sender, cur_own, 16'h0100, CHK_GOOD);
    send_stim();

    set_ids(8'h5A, 8'hA5);
    hold_req = 1'b1;
    random_traffic(300);

    in_idle();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (FLUSH_CYCLES) @(posedge clk_i);
    $display("Sent %0d bytes under five ID settings; checked %0d results.",
             items_sent, sb.n_results);
    $display("Frames: %0d good, %0d bad; %0d payload bytes, longest frame %0d bytes.",
             sb.n_good, sb.n_bad, sb.n_payload, sb.longest_frame);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
